// ----- rtl/isa_pkg.sv -----
// Package with widths, operation and status codes, and cell control types for the shift array.
package isa_pkg;

    localparam int CW = 6;
    localparam int DW = 32;
    localparam int DEF_DEPTH = 32;

    localparam logic [2:0] FN_APPEND = 3'd0;
    localparam logic [2:0] FN_REMOVE = 3'd1;
    localparam logic [2:0] FN_INSERT = 3'd2;
    localparam logic [2:0] FN_DELETE = 3'd3;
    localparam logic [2:0] FN_LIST   = 3'd4;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_INS_REFUSE = 2'd1;
    localparam logic [1:0] ST_DEL_REFUSE = 2'd2;
    localparam logic [1:0] ST_LIST_EMPTY = 2'd3;

    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_DELETE = 2'd2;
    localparam logic [1:0] CELL_ROTATE = 2'd3;

    typedef struct packed {
        logic [1:0]           op;
        logic [CW-1:0]        pos;
        logic [CW-1:0]        last_idx;
        logic signed [DW-1:0] value;
    } isa_cell_ctrl_t;

endpackage

// ----- rtl/isa_channels.sv -----
// Valid/ready channel interfaces for the shift array input and result streams.
interface isa_in_if
    import isa_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [2:0]           func;
    logic [CW-1:0]        position;
    logic signed [DW-1:0] value;

    modport source (output valid, output func, output position, output value, input ready);
    modport sink (input valid, input func, input position, input value, output ready);
endinterface

interface isa_out_if
    import isa_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic signed [DW-1:0] item;
    logic [CW-1:0]        item_position;
    logic [CW-1:0]        entry_count;
    logic                 last;

    modport source (output valid, output status, output item, output item_position,
                    output entry_count, output last, input ready);
    modport sink (input valid, input status, input item, input item_position,
                  input entry_count, input last, output ready);
endinterface

// ----- rtl/isa_cell.sv -----
// One storage cell of the shift chain, holding a single entry.
module isa_cell
    import isa_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic                 clk,
    input  isa_cell_ctrl_t       ctrl,
    input  logic signed [DW-1:0] prev_data,
    input  logic signed [DW-1:0] next_data,
    input  logic signed [DW-1:0] head_data,
    output logic signed [DW-1:0] data
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic signed [DW-1:0] data_reg;
    logic signed [DW-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (MY_IDX == ctrl.pos)
                    data_next = ctrl.value;
                else if (MY_IDX > ctrl.pos)
                    data_next = prev_data;
            end
            CELL_DELETE:
            begin
                if (MY_IDX >= ctrl.pos)
                    data_next = next_data;
            end
            CELL_ROTATE:
            begin
                if (MY_IDX == ctrl.last_idx)
                    data_next = head_data;
                else if (MY_IDX < ctrl.last_idx)
                    data_next = next_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- rtl/isa_ctrl.sv -----
// Controller that checks each operation, keeps the entry count, drives the chain and the result register.
module isa_ctrl
    import isa_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    isa_in_if.sink               in_ch,
    isa_out_if.source            out_ch,
    input  logic signed [DW-1:0] head_data,
    output isa_cell_ctrl_t       cell_ctrl
);

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic          S_IDLE  = 1'b0;
    localparam logic          S_LIST  = 1'b1;

    logic                 state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic                 ovalid_reg, ovalid_next;
    logic [1:0]           status_reg, status_next;
    logic signed [DW-1:0] item_reg, item_next;
    logic [CW-1:0]        ipos_reg, ipos_next;
    logic [CW-1:0]        ecount_reg, ecount_next;
    logic                 last_reg, last_next;

    logic          out_free;
    logic          accept;
    logic          emit;
    logic [CW-1:0] last_idx;

    assign out_free     = !ovalid_reg || out_ch.ready;
    assign in_ch.ready  = (state_reg == S_IDLE) && out_free;
    assign accept       = in_ch.valid && in_ch.ready;
    assign last_idx     = count_reg - CW'(1);

    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        idx_next           = idx_reg;
        emit               = 1'b0;
        status_next        = status_reg;
        item_next          = item_reg;
        ipos_next          = ipos_reg;
        last_next          = last_reg;
        cell_ctrl.op       = CELL_HOLD;
        cell_ctrl.pos      = in_ch.position;
        cell_ctrl.last_idx = last_idx;
        cell_ctrl.value    = in_ch.value;

        if (state_reg == S_IDLE)
        begin
            if (accept)
            begin
                emit        = 1'b1;
                status_next = ST_OK;
                item_next   = '0;
                ipos_next   = '0;
                last_next   = 1'b1;
                case (in_ch.func)
                    FN_APPEND:
                    begin
                        if (count_reg >= DEPTH_C)
                            status_next = ST_INS_REFUSE;
                        else
                        begin
                            cell_ctrl.op  = CELL_INSERT;
                            cell_ctrl.pos = count_reg;
                            count_next    = count_reg + CW'(1);
                        end
                    end
                    FN_REMOVE:
                    begin
                        if (count_reg == '0)
                            status_next = ST_DEL_REFUSE;
                        else
                        begin
                            cell_ctrl.op  = CELL_DELETE;
                            cell_ctrl.pos = last_idx;
                            count_next    = last_idx;
                        end
                    end
                    FN_INSERT:
                    begin
                        if (count_reg >= DEPTH_C || in_ch.position > count_reg)
                            status_next = ST_INS_REFUSE;
                        else
                        begin
                            cell_ctrl.op = CELL_INSERT;
                            count_next   = count_reg + CW'(1);
                        end
                    end
                    FN_DELETE:
                    begin
                        if (count_reg == '0 || in_ch.position >= count_reg)
                            status_next = ST_DEL_REFUSE;
                        else
                        begin
                            cell_ctrl.op = CELL_DELETE;
                            count_next   = last_idx;
                        end
                    end
                    FN_LIST:
                    begin
                        if (count_reg == '0)
                            status_next = ST_LIST_EMPTY;
                        else
                        begin
                            emit       = 1'b0;
                            state_next = S_LIST;
                            idx_next   = '0;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
        end
        else if (out_free)
        begin
            // Entry zero is read out while the chain rotates by one place.
            emit         = 1'b1;
            status_next  = ST_OK;
            item_next    = head_data;
            ipos_next    = idx_reg;
            last_next    = (idx_reg == last_idx);
            cell_ctrl.op = CELL_ROTATE;
            idx_next     = idx_reg + CW'(1);
            if (idx_reg == last_idx)
                state_next = S_IDLE;
        end

        ecount_next = count_next;
        ovalid_next = emit || (ovalid_reg && !out_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg <= status_next;
            item_reg   <= item_next;
            ipos_reg   <= ipos_next;
            ecount_reg <= ecount_next;
            last_reg   <= last_next;
        end
    end

    assign out_ch.valid         = ovalid_reg;
    assign out_ch.status        = status_reg;
    assign out_ch.item          = item_reg;
    assign out_ch.item_position = ipos_reg;
    assign out_ch.entry_count   = ecount_reg;
    assign out_ch.last          = last_reg;

endmodule

// ----- rtl/indexed_shift_array_unit.sv -----
// Top level of the indexed shift array: a chain of entry cells and its controller.
//
// Usage: operations arrive on in_ch (func, position, value) and results leave on
// out_ch (status, item, item_position, entry_count, last). A transaction occurs
// when valid and ready are both high at a rising clock edge.
// For append, remove last, insert and delete, the cells from the position on
// load at the same edge, so later entries move in one step. The result is
// registered and shows on out_ch in the cycle after the input transaction,
// and a new operation may be accepted every cycle while the result register
// is empty or being read.
// A listing emits one result per cycle while the result register is empty or
// being read, taken from the first cell while the chain rotates by one place;
// input is not accepted until its last result is registered.
// The rotation leaves the entries in their original order at the end.
// Reset clears the entry count, the controller state and the result valid;
// cell contents are not reset and are never read out at or above the count.
// When the receiver holds ready low, the result register holds its value and
// input stops being accepted until that result is taken.
module indexed_shift_array_unit
    import isa_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    isa_in_if.sink    in_ch,
    isa_out_if.source out_ch
);

    isa_cell_ctrl_t       cell_ctrl;
    logic signed [DW-1:0] cell_data [DEPTH];

    isa_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .head_data (cell_data[0]),
        .cell_ctrl (cell_ctrl)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DW-1:0] prev_d;
        logic signed [DW-1:0] next_d;

        if (i == 0)
        begin : g_first
            assign prev_d = cell_data[i];
        end
        else
        begin : g_mid_prev
            assign prev_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_lastc
            assign next_d = cell_data[i];
        end
        else
        begin : g_mid_next
            assign next_d = cell_data[i+1];
        end

        isa_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .prev_data (prev_d),
            .next_data (next_d),
            .head_data (cell_data[0]),
            .data      (cell_data[i])
        );
    end

endmodule

// ----- rtl/isa_checker.sv -----
// Port-level checker for the indexed shift array, bound to the top level.
module isa_checker
    import isa_pkg::*;
#(
    parameter int DEPTH = DEF_DEPTH
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [1:0]           out_status,
    input logic signed [DW-1:0] out_item,
    input logic [CW-1:0]        out_entry_count,
    input logic                 out_last
);

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // A stalled result stays valid and keeps its item and status.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item) && $stable(out_status))
        else $error("result changed while stalled");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_entry_count <= DEPTH_C)
        else $error("entry count above depth");

    a_empty_list: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status == ST_LIST_EMPTY |-> out_entry_count == '0 && out_last)
        else $error("empty list result malformed");

    // Only listing produces results that are not last, and no input is taken meanwhile.
    a_list_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> out_status == ST_OK && !in_ready)
        else $error("input accepted during listing");

endmodule

bind indexed_shift_array_unit isa_checker #(
    .DEPTH (DEPTH)
) u_isa_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_item        (out_ch.item),
    .out_entry_count (out_ch.entry_count),
    .out_last        (out_ch.last)
);
